@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the resizing stack core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);
// Check that a condition implies a consequence on the next clock edge
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

@@ src/rscp_pkg.sv @@
// Shared constants, types and codes of the resizing stack core
`timescale 1ns / 1ps
package rscp_pkg;

  localparam int DEPTH        = 1024;
  localparam int MIN_CAPACITY = 15;
  localparam int EFF_MIN      = (MIN_CAPACITY < DEPTH) ? MIN_CAPACITY : DEPTH;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CAP_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int REG_W   = 16;
  localparam int FRAC_W  = 12;
  localparam int CNT_W   = 32;
  localparam int PROD_W  = REG_W + CAP_W;
  localparam int SCALE_W = PROD_W - FRAC_W;
  localparam int IDX_W   = 2;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_FULL_THR   = 2'd0,
    REG_EMPTY_THR  = 2'd1,
    REG_GROW_RATIO = 2'd2,
    REG_SHRK_RATIO = 2'd3
  } reg_index_t;

  // Resize outcome codes
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_GROW   = 2'd1,
    ACT_SHRINK = 2'd2
  } resize_act_t;

  typedef struct packed {
    logic [REG_W-1:0] full_thr;
    logic [REG_W-1:0] empty_thr;
    logic [REG_W-1:0] grow_ratio;
    logic [REG_W-1:0] shrink_ratio;
  } policy_cfg_t;

  typedef struct packed {
    resize_act_t      act;
    logic [CAP_W-1:0] cap;
  } policy_res_t;

endpackage

@@ src/resizing_stack_capacity_policy_core.sv @@
// Top level of the resizing stack with grow and shrink capacity policy
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Each command is accepted and then executed. In the accept cycle the stack
// memory is written (even value, push) or read at the top entry (odd value,
// pop) and the four threshold and ratio products of the current capacity are
// registered; in the execute state the new fill is compared against them,
// the capacity, peak and counters are updated and the result beat is loaded
// into the output register. The next command is taken once the result is
// loaded. A result beat that is still waiting holds a command in the execute
// state until that beat is taken; the new beat is loaded at the same edge.
// The stack memory needs no clearing after reset: a pop only reads entries
// a push has written. Configuration writes take effect at once and should
// be made only while no command is in progress.
module resizing_stack_capacity_policy_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rscp_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rscp_pkg::REG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rscp_pkg::DATA_W-1:0] command_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rscp_pkg::DATA_W-1:0] popped_value,
  output logic                              pop_valid,
  output logic                              push_overflow,
  output logic [rscp_pkg::CAP_W-1:0]        entry_count,
  output logic [rscp_pkg::CAP_W-1:0]        logical_capacity,
  output logic [rscp_pkg::CAP_W-1:0]        peak_capacity,
  output logic [1:0]                        resize_action,
  output logic [rscp_pkg::CNT_W-1:0]        resize_total,
  output logic [rscp_pkg::CNT_W-1:0]        commands_seen
);
  import rscp_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state;
  policy_cfg_t       cfg;
  logic [CAP_W-1:0]  fill;
  logic [CAP_W-1:0]  fill_next;
  logic [CAP_W-1:0]  cap_now;
  logic [CAP_W-1:0]  cap_peak;
  logic [CNT_W-1:0]  resize_cnt;
  logic [CNT_W-1:0]  cmd_cnt;
  logic              pop_hit;
  logic              ovf_hit;
  logic              accept;
  logic              is_pop;
  logic              fill_full;
  logic              fill_empty;
  logic              ram_wr;
  logic              ram_rd;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rd_data;
  logic              load_out;
  policy_res_t       pol;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_pop     = command_value[0];
  assign fill_full  = (fill == CAP_W'(DEPTH));
  assign fill_empty = (fill == '0);
  assign ram_wr     = accept && !is_pop && !fill_full;
  assign ram_rd     = accept && is_pop && !fill_empty;
  assign ram_addr   = ram_rd ? ADDR_W'(fill - CAP_W'(1)) : fill[ADDR_W-1:0];
  assign load_out   = (state == S_EXEC) && (!out_valid || out_ready);

  // New fill after the command
  always_comb begin
    fill_next = fill;
    if (ram_wr) begin
      fill_next = fill + CAP_W'(1);
    end else if (ram_rd) begin
      fill_next = fill - CAP_W'(1);
    end
  end

  rscp_stack_ram #(
    .ADDR_BITS (ADDR_W),
    .WORD_BITS (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .rd_en   (ram_rd),
    .addr    (ram_addr),
    .wr_data (command_value),
    .rd_data (ram_rd_data)
  );

  rscp_policy u_policy (
    .clk     (clk),
    .capture (accept),
    .cfg     (cfg),
    .cap_now (cap_now),
    .fill    (fill),
    .res     (pol)
  );

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_thr     <= REG_W'(4096);
      cfg.empty_thr    <= REG_W'(614);
      cfg.grow_ratio   <= REG_W'(8192);
      cfg.shrink_ratio <= REG_W'(2048);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_FULL_THR:   cfg.full_thr     <= cfg_data;
        REG_EMPTY_THR:  cfg.empty_thr    <= cfg_data;
        REG_GROW_RATIO: cfg.grow_ratio   <= cfg_data;
        REG_SHRK_RATIO: cfg.shrink_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence one command, update stack state and load the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      cap_now    <= CAP_W'(EFF_MIN);
      cap_peak   <= CAP_W'(EFF_MIN);
      resize_cnt <= '0;
      cmd_cnt    <= '0;
      pop_hit    <= 1'b0;
      ovf_hit    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill    <= fill_next;
            pop_hit <= ram_rd;
            ovf_hit <= accept && !is_pop && fill_full;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (load_out) begin
            cap_now <= pol.cap;
            if (pol.cap > cap_peak) begin
              cap_peak <= pol.cap;
            end
            if (pol.act != ACT_NONE && resize_cnt != '1) begin
              resize_cnt <= resize_cnt + CNT_W'(1);
            end
            if (cmd_cnt != '1) begin
              cmd_cnt <= cmd_cnt + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Raise valid when a beat is loaded, drop it once the beat is taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      popped_value     <= pop_hit ? ram_rd_data : '0;
      pop_valid        <= pop_hit;
      push_overflow    <= ovf_hit;
      entry_count      <= fill;
      logical_capacity <= pol.cap;
      peak_capacity    <= (pol.cap > cap_peak) ? pol.cap : cap_peak;
      resize_action    <= pol.act;
      resize_total     <= (pol.act != ACT_NONE && resize_cnt != '1) ?
                          resize_cnt + CNT_W'(1) : resize_cnt;
      commands_seen    <= (cmd_cnt != '1) ? cmd_cnt + CNT_W'(1) : cmd_cnt;
    end
  end

  `ASSERT_NEXT(a_accept_blocks, clk, rst, accept, !in_ready && state == S_EXEC, "accept did not start execution")
  `ASSERT_ALWAYS(a_cap_range, clk, rst, cap_now >= CAP_W'(EFF_MIN) && cap_now <= CAP_W'(DEPTH) && cap_peak >= cap_now, "capacity out of range")
  `ASSERT_ALWAYS(a_fill_range, clk, rst, fill <= CAP_W'(DEPTH), "fill above depth")
  `ASSERT_NEXT(a_result_loaded, clk, rst, load_out, out_valid && in_ready, "result beat not loaded")

endmodule

@@ src/rscp_stack_ram.sv @@
// Single-port synchronous stack memory with registered read data
`timescale 1ns / 1ps
module rscp_stack_ram #(
  parameter int ADDR_BITS = 10,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [2**ADDR_BITS];

  // Write on push, register read data on pop
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ src/rscp_policy.sv @@
// Capacity policy: registered threshold and ratio products, then compare and clamp
`timescale 1ns / 1ps
module rscp_policy (
  input  logic                         clk,
  input  logic                         capture,
  input  rscp_pkg::policy_cfg_t        cfg,
  input  logic [rscp_pkg::CAP_W-1:0]   cap_now,
  input  logic [rscp_pkg::CAP_W-1:0]   fill,
  output rscp_pkg::policy_res_t        res
);
  import rscp_pkg::*;

  logic [PROD_W-1:0] full_prod;
  logic [PROD_W-1:0] empty_prod;
  logic [PROD_W-1:0] grow_prod;
  logic [PROD_W-1:0] shrink_prod;
  logic [PROD_W-1:0] fill_scaled;

  // Saturate a scaled capacity into [EFF_MIN, DEPTH]
  function automatic logic [CAP_W-1:0] clamp_cap(input logic [SCALE_W-1:0] v);
    logic [CAP_W-1:0] r;
    if (v > SCALE_W'(DEPTH)) begin
      r = CAP_W'(DEPTH);
    end else if (v < SCALE_W'(EFF_MIN)) begin
      r = CAP_W'(EFF_MIN);
    end else begin
      r = v[CAP_W-1:0];
    end
    return r;
  endfunction

  // Form all products from the capacity held before the command
  always_ff @(posedge clk) begin
    if (capture) begin
      full_prod   <= PROD_W'(cfg.full_thr)     * PROD_W'(cap_now);
      empty_prod  <= PROD_W'(cfg.empty_thr)    * PROD_W'(cap_now);
      grow_prod   <= PROD_W'(cfg.grow_ratio)   * PROD_W'(cap_now);
      shrink_prod <= PROD_W'(cfg.shrink_ratio) * PROD_W'(cap_now);
    end
  end

  assign fill_scaled = PROD_W'(fill) << FRAC_W;

  // Compare the new fill against both thresholds and pick the new capacity
  always_comb begin
    res.act = ACT_NONE;
    res.cap = cap_now;
    if (fill_scaled >= full_prod) begin
      res.act = ACT_GROW;
      res.cap = clamp_cap(grow_prod[PROD_W-1:FRAC_W]);
    end else if (fill_scaled <= empty_prod && cap_now > CAP_W'(EFF_MIN)) begin
      res.act = ACT_SHRINK;
      res.cap = clamp_cap(shrink_prod[PROD_W-1:FRAC_W]);
    end
  end

endmodule
